// File: src/wrs_pkg.sv
// Shared types and constants for the weighted reservoir sampler.
// Used by every module of the block; depends on nothing else.

package wrs_pkg;

   localparam int OSUM_W  = 48;
   localparam int COUNT_W = 20;
   localparam int DIV_NUM_W = OSUM_W + COUNT_W;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_MERGE = 2'd2;

   // Classified operation kinds handed from the front to the back.
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_ADD   = 3'd1;
   localparam logic [2:0] KIND_COUNT = 3'd2;
   localparam logic [2:0] KIND_MERGE = 3'd3;
   localparam logic [2:0] KIND_NOP   = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_CAP   = 20'd1000000;
   localparam logic [COUNT_W-1:0] MHC_RESET   = 20'd20;
   localparam logic [31:0]        NO_LIGHT    = 32'hFFFF_FFFF;
   localparam logic [31:0]        RNG_GOLDEN  = 32'h9E37_79B9;
   localparam logic [31:0]        RNG_MUL1    = 32'h21F0_AAAD;
   localparam logic [31:0]        RNG_MUL2    = 32'h735A_2D97;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        seed;
      logic [31:0]        light_index;
      logic [31:0]        candidate_weight;
      logic [31:0]        target_value;
      logic [OSUM_W-1:0]  other_weight_sum;
      logic [COUNT_W-1:0] other_count;
      logic               clamp_history;
   } req_type;

   typedef struct packed {
      logic [31:0]        pick_light;
      logic [OSUM_W-1:0]  weight_sum;
      logic [COUNT_W-1:0] sample_count;
      logic [31:0]        chosen_target;
      logic               has_pick;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        word;     // seed for a start, light otherwise
      logic [31:0]        weight;
      logic [31:0]        target;
      logic [OSUM_W-1:0]  osum;
      logic [COUNT_W-1:0] ocount;   // already capped at one million
      logic               clamp;
   } op_type;

endpackage

// File: src/wrs_front.sv
// Front end: accepts request beats, classifies them and hands operations on.
// Depends on wrs_pkg.

module wrs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wrs_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output wrs_pkg::op_type  push_op
);

   logic            hold_valid_ff, hold_valid_in;
   wrs_pkg::op_type hold_op_ff, hold_op_in;
   logic            accept;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_op    = hold_op_ff;

   always_comb begin
      hold_op_in.word   = (req_data.command == wrs_pkg::CMD_START) ? req_data.seed
                                                                     : req_data.light_index;
      hold_op_in.weight = req_data.candidate_weight;
      hold_op_in.target = req_data.target_value;
      hold_op_in.osum   = req_data.other_weight_sum;
      hold_op_in.ocount = (req_data.other_count > wrs_pkg::COUNT_CAP) ? wrs_pkg::COUNT_CAP
                                                                      : req_data.other_count;
      hold_op_in.clamp  = req_data.clamp_history;
      case (req_data.command)
         wrs_pkg::CMD_START: hold_op_in.kind = wrs_pkg::KIND_START;
         wrs_pkg::CMD_ADD: begin
            // A zero weight only bumps the count and makes no draw.
            hold_op_in.kind = (req_data.candidate_weight != 32'd0) ? wrs_pkg::KIND_ADD
                                                                   : wrs_pkg::KIND_COUNT;
         end
         wrs_pkg::CMD_MERGE: hold_op_in.kind = wrs_pkg::KIND_MERGE;
         default: hold_op_in.kind = wrs_pkg::KIND_NOP;
      endcase
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_op_ff <= hold_op_in;
      end
   end

endmodule

// File: src/wrs_queue.sv
// Two-entry operation queue between the front end and the execution back end.
// Depends on wrs_pkg.

module wrs_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  wrs_pkg::op_type in_op,
   output logic            out_valid,
   input  logic            out_ready,
   output wrs_pkg::op_type out_op
);

   wrs_pkg::op_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_op    = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_op;
      end
   end

endmodule

// File: src/wrs_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Used by the back end for the history clamp; depends on wrs_pkg.

module wrs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wrs_pkg::DIV_NUM_W-1:0]     numerator,
   input  logic [wrs_pkg::COUNT_W-1:0]       denominator,
   output logic                              done,
   output logic [wrs_pkg::DIV_NUM_W-1:0]     quotient
);

   localparam int NumW = wrs_pkg::DIV_NUM_W;
   localparam int DenW = wrs_pkg::COUNT_W;
   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0] work_ff, work_in;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [DenW-1:0] den_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DenW:0]   rem_shift;
   logic [DenW:0]   rem_diff;
   logic            fits;

   assign done     = done_ff;
   assign quotient = work_ff;

   // The remainder stays below the divisor, so the shifted value is below twice it.
   assign rem_shift = {rem_ff, work_ff[NumW-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = numerator;
         rem_in  = '0;
         cnt_in  = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[NumW-2:0], fits};
         rem_in  = fits ? rem_diff[DenW-1:0] : rem_shift[DenW-1:0];
         cnt_in  = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= denominator;
      end
   end

endmodule

// File: src/wrs_back.sv
// Execution back end: reservoir state, random draws, merge weighting and the
// result register. Depends on wrs_pkg and wrs_div.

module wrs_back #(
   parameter int SUM_BITS = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   output logic                        op_ready,
   input  wrs_pkg::op_type             op_data,
   input  logic [wrs_pkg::COUNT_W-1:0] max_history_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output wrs_pkg::rsp_type            rsp_data
);

   localparam int OsumW    = wrs_pkg::OSUM_W;
   localparam int CountW   = wrs_pkg::COUNT_W;
   localparam int SumWideW = (SUM_BITS > OsumW) ? SUM_BITS : OsumW;
   localparam logic [SUM_BITS-1:0] SumMax   = {SUM_BITS{1'b1}};
   localparam logic [OsumW-1:0]    OsumMask = (SUM_BITS >= OsumW) ? {OsumW{1'b1}}
                                                                  : OsumW'(SumMax);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXEC  = 4'd1;
   localparam logic [3:0] ST_CLMUL = 4'd2;
   localparam logic [3:0] ST_CLSUM = 4'd3;
   localparam logic [3:0] ST_CLDIV = 4'd4;
   localparam logic [3:0] ST_WBMUL = 4'd5;
   localparam logic [3:0] ST_WBSUM = 4'd6;
   localparam logic [3:0] ST_MIX1  = 4'd7;
   localparam logic [3:0] ST_MIX2  = 4'd8;
   localparam logic [3:0] ST_SCALE = 4'd9;
   localparam logic [3:0] ST_PICK  = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic [3:0]          state_ff, state_in;
   wrs_pkg::op_type     op_ff, op_in;
   logic [31:0]         light_ff, light_in;
   logic [31:0]         target_ff, target_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic                pick_ff, pick_in;
   logic [31:0]         rng_ff, rng_in;
   logic [31:0]         mix_ff, mix_in;
   logic [SUM_BITS-1:0] wgt_ff, wgt_in;
   logic [63:0]         prod_lo_ff, prod_lo_in;
   logic [63:0]         prod_hi_ff, prod_hi_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wrs_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_load;

   logic [51:0]         clamp_lo;
   logic [35:0]         clamp_hi;
   logic [63:0]         wb_lo;
   logic [47:0]         wb_hi;
   logic [31:0]         rng_next;
   logic [31:0]         mix1_src, mix1_prod;
   logic [31:0]         mix2_src, mix2_prod;
   logic [31:0]         draw;
   logic [63:0]         draw_lo;
   logic [SUM_BITS-1:0] draw_hi;
   logic [64:0]         wb_full;
   logic [SUM_BITS-1:0] wb_sat;
   logic [SUM_BITS:0]   scaled;
   logic [SumWideW-1:0] sum_wide;

   logic                           div_start;
   logic                           div_done;
   logic [wrs_pkg::DIV_NUM_W-1:0]  div_num;
   logic [wrs_pkg::DIV_NUM_W-1:0]  div_quot;

   function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? SumMax : s[SUM_BITS-1:0];
   endfunction

   function automatic logic [CountW-1:0] sat_count(input logic [CountW-1:0] a,
                                                   input logic [CountW-1:0] b);
      logic [CountW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, wrs_pkg::COUNT_CAP}) ? wrs_pkg::COUNT_CAP : s[CountW-1:0];
   endfunction

   // Multipliers; every product lands in a register before it is used.
   assign clamp_lo  = op_ff.osum[31:0] * max_history_count;
   assign clamp_hi  = op_ff.osum[OsumW-1:32] * max_history_count;
   assign wb_lo     = op_ff.target * op_ff.osum[31:0];
   assign wb_hi     = op_ff.target * op_ff.osum[OsumW-1:32];
   assign rng_next  = rng_ff + wrs_pkg::RNG_GOLDEN;
   assign mix1_src  = rng_next ^ (rng_next >> 16);
   assign mix1_prod = mix1_src * wrs_pkg::RNG_MUL1;
   assign mix2_src  = mix_ff ^ (mix_ff >> 15);
   assign mix2_prod = mix2_src * wrs_pkg::RNG_MUL2;
   assign draw      = mix_ff ^ (mix_ff >> 15);
   assign draw_lo   = draw * sum_ff[31:0];
   assign draw_hi   = draw * sum_ff[SUM_BITS-1:32];

   // Merge weight is floor(target * sum / 2^16), saturating.
   assign wb_full = {1'b0, prod_hi_ff[47:0], 16'd0} + 65'(prod_lo_ff[63:16]);
   assign wb_sat  = ((wb_full >> SUM_BITS) != 65'd0) ? SumMax : wb_full[SUM_BITS-1:0];
   // Upper word of draw * sum, i.e. floor(draw * sum / 2^32).
   assign scaled  = {1'b0, prod_hi_ff[SUM_BITS-1:0]} + (SUM_BITS + 1)'(prod_lo_ff[63:32]);
   assign div_num = {prod_hi_ff[35:0], 32'd0} + wrs_pkg::DIV_NUM_W'(prod_lo_ff[51:0]);

   assign sum_wide  = SumWideW'(sum_ff);
   assign op_ready  = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wrs_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (op_ff.ocount),
      .done        (div_done),
      .quotient    (div_quot)
   );

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      light_in   = light_ff;
      target_in  = target_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      pick_in    = pick_ff;
      rng_in     = rng_ff;
      mix_in     = mix_ff;
      wgt_in     = wgt_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      rsp_in.pick_light    = light_ff;
      rsp_in.weight_sum    = sum_wide[OsumW-1:0];
      rsp_in.sample_count  = count_ff;
      rsp_in.chosen_target = target_ff;
      rsp_in.has_pick      = pick_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_in      = op_data;
               op_in.osum = op_data.osum & OsumMask;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff.kind)
               wrs_pkg::KIND_START: begin
                  light_in  = wrs_pkg::NO_LIGHT;
                  target_in = 32'd0;
                  sum_in    = '0;
                  count_in  = '0;
                  pick_in   = 1'b0;
                  rng_in    = op_ff.word;
                  state_in  = ST_OUT;
               end
               wrs_pkg::KIND_COUNT: begin
                  count_in = sat_count(count_ff, CountW'(1));
                  state_in = ST_OUT;
               end
               wrs_pkg::KIND_ADD: begin
                  count_in = sat_count(count_ff, CountW'(1));
                  sum_in   = sat_sum(sum_ff, SUM_BITS'(op_ff.weight));
                  wgt_in   = SUM_BITS'(op_ff.weight);
                  state_in = ST_MIX1;
               end
               wrs_pkg::KIND_MERGE: begin
                  if (op_ff.clamp && (op_ff.ocount > max_history_count)) begin
                     state_in = ST_CLMUL;
                  end else begin
                     state_in = ST_WBMUL;
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_CLMUL: begin
            prod_lo_in = 64'(clamp_lo);
            prod_hi_in = 64'(clamp_hi);
            state_in   = ST_CLSUM;
         end
         ST_CLSUM: begin
            div_start = 1'b1;
            state_in  = ST_CLDIV;
         end
         ST_CLDIV: begin
            // The clamped sum is floor(sum * limit / count), at most the original sum.
            if (div_done) begin
               op_in.osum   = div_quot[OsumW-1:0];
               op_in.ocount = max_history_count;
               state_in     = ST_WBMUL;
            end
         end
         ST_WBMUL: begin
            prod_lo_in = wb_lo;
            prod_hi_in = 64'(wb_hi);
            if ((op_ff.ocount == '0) || (op_ff.target == 32'd0)) begin
               count_in = sat_count(count_ff, op_ff.ocount);
               state_in = ST_OUT;
            end else begin
               state_in = ST_WBSUM;
            end
         end
         ST_WBSUM: begin
            count_in = sat_count(count_ff, op_ff.ocount);
            if (wb_sat == '0) begin
               state_in = ST_OUT;
            end else begin
               sum_in   = sat_sum(sum_ff, wb_sat);
               wgt_in   = wb_sat;
               state_in = ST_MIX1;
            end
         end
         ST_MIX1: begin
            rng_in   = rng_next;
            mix_in   = mix1_prod;
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            mix_in   = mix2_prod;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_lo_in = draw_lo;
            prod_hi_in = 64'(draw_hi);
            state_in   = ST_PICK;
         end
         ST_PICK: begin
            if (scaled < {1'b0, wgt_ff}) begin
               light_in  = op_ff.word;
               target_in = op_ff.target;
               pick_in   = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         light_ff     <= wrs_pkg::NO_LIGHT;
         target_ff    <= 32'd0;
         sum_ff       <= '0;
         count_ff     <= '0;
         pick_ff      <= 1'b0;
         rng_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         light_ff     <= light_in;
         target_ff    <= target_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         pick_ff      <= pick_in;
         rng_ff       <= rng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      mix_ff     <= mix_in;
      wgt_ff     <= wgt_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: src/weighted_reservoir_sampler_unit.sv
// Top level of the weighted reservoir sampler: front end, queue, back end and
// the history limit register. Depends on wrs_pkg, wrs_front, wrs_queue, wrs_back.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | wrs_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready  | wrs_pkg::rsp_type
//   csr     | in        | csr_wr_en            | csr_wr_data (max history count)
//
// Each beat gives exactly one response. The back end runs one operation at a time:
// start, zero-weight add and unused commands go straight to the output; an add mixes
// a draw, scales it and picks; a merge first forms its weight, stopping when its count,
// target or rounded weight is zero; a clamped merge runs the 68-step serial divider first.
// Reset is synchronous and restores the empty reservoir and a limit of 20. The front end and
// two-entry queue take beats until full while the back end works or waits on rsp_ready.

module weighted_reservoir_sampler_unit #(
   parameter int SUM_BITS = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  wrs_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output wrs_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [wrs_pkg::COUNT_W-1:0] csr_wr_data
);

   logic [wrs_pkg::COUNT_W-1:0] mhc_ff, mhc_in;
   logic                        push_valid, push_ready;
   wrs_pkg::op_type             push_op;
   logic                        pop_valid, pop_ready;
   wrs_pkg::op_type             pop_op;

   assign mhc_in = csr_wr_en ? csr_wr_data : mhc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mhc_ff <= wrs_pkg::MHC_RESET;
      end else begin
         mhc_ff <= mhc_in;
      end
   end

   wrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   wrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_op     (push_op),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_op    (pop_op)
   );

   wrs_back #(
      .SUM_BITS (SUM_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (pop_valid),
      .op_ready          (pop_ready),
      .op_data           (pop_op),
      .max_history_count (mhc_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data)
   );

endmodule

// File: src/wrs_checker.sv
// Port-level checks for the weighted reservoir sampler, bound to the top level.
// Depends on wrs_pkg and weighted_reservoir_sampler_unit.

module wrs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wrs_pkg::rsp_type rsp_data
);

   // A response beat that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample_count <= wrs_pkg::COUNT_CAP)
      else $error("sample count above its cap");

   // Without a pick the reservoir shows the empty light and a zero target.
   a_no_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_pick |->
         rsp_data.pick_light == wrs_pkg::NO_LIGHT && rsp_data.chosen_target == 32'd0)
      else $error("light or target set without a pick");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind weighted_reservoir_sampler_unit wrs_checker u_wrs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: test/tb_weighted_reservoir_sampler_unit.sv
// Self-checking testbench for weighted_reservoir_sampler_unit: directed corner cases,
// history limit sweeps and random reservoir traffic under sender idling and receiver stalls.
// Depends on wrs_pkg and the sampler RTL only.

module tb_weighted_reservoir_sampler_unit;

   localparam int SUM_BITS = 48;
   localparam int COUNT_W = wrs_pkg::COUNT_W;
   localparam int OSUM_W = wrs_pkg::OSUM_W;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   wrs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   wrs_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   // Predicted reservoir state and the history limit register.
   logic [31:0] res_light;
   logic [SUM_BITS-1:0] res_sum;
   logic [COUNT_W-1:0] res_count;
   logic [31:0] res_target;
   logic [31:0] res_rng;
   logic res_has_pick;
   logic [COUNT_W-1:0] hist_limit;

   wrs_pkg::rsp_type pending_reservoirs[$];
   wrs_pkg::rsp_type want;
   int mismatch_count = 0;
   int beats_sent = 0;
   int rsp_checked = 0;
   int clamped_merges = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   weighted_reservoir_sampler_unit #(.SUM_BITS(SUM_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [31:0] next_random();
      logic [31:0] z;
      res_rng = res_rng + wrs_pkg::RNG_GOLDEN;
      z = res_rng;
      z = (z ^ (z >> 16)) * wrs_pkg::RNG_MUL1;
      z = (z ^ (z >> 15)) * wrs_pkg::RNG_MUL2;
      return z ^ (z >> 15);
   endfunction

   function automatic logic [SUM_BITS-1:0] sum_saturating(logic [SUM_BITS-1:0] a,
                                                          logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
   endfunction

   function automatic void count_add(logic [COUNT_W-1:0] c);
      logic [COUNT_W:0] s;
      s = {1'b0, res_count} + {1'b0, c};
      res_count = (s > wrs_pkg::COUNT_CAP) ? wrs_pkg::COUNT_CAP : s[COUNT_W-1:0];
   endfunction

   // Keep the candidate when floor(r * sum / 2^32) is below its weight.
   function automatic void draw_and_pick(logic [SUM_BITS-1:0] w, logic [31:0] light,
                                         logic [31:0] target);
      logic [SUM_BITS+31:0] prod;
      prod = next_random() * res_sum;
      if (prod[SUM_BITS+31:32] < w) begin
         res_light = light;
         res_target = target;
         res_has_pick = 1'b1;
      end
   endfunction

   function automatic logic [SUM_BITS-1:0] merge_weight(logic [31:0] t, logic [SUM_BITS-1:0] s);
      logic [SUM_BITS+31:0] prod;
      prod = t * s;
      return (prod[SUM_BITS+31:SUM_BITS+16] != 0) ? SUM_MAX : prod[SUM_BITS+15:16];
   endfunction

   function automatic void clear_reservoir();
      res_light = wrs_pkg::NO_LIGHT;
      res_sum = '0;
      res_count = '0;
      res_target = '0;
      res_has_pick = 1'b0;
   endfunction

   function automatic wrs_pkg::rsp_type apply_to_reservoir(wrs_pkg::req_type item);
      logic [COUNT_W-1:0] cnt;
      logic [SUM_BITS-1:0] osum;
      logic [SUM_BITS-1:0] wb;
      logic [SUM_BITS+COUNT_W-1:0] scaled;
      wrs_pkg::rsp_type r;
      case (item.command)
         wrs_pkg::CMD_START: begin
            clear_reservoir();
            res_rng = item.seed;
         end
         wrs_pkg::CMD_ADD: begin
            count_add(COUNT_W'(1));
            if (item.candidate_weight != 0) begin
               res_sum = sum_saturating(res_sum, SUM_BITS'(item.candidate_weight));
               draw_and_pick(SUM_BITS'(item.candidate_weight), item.light_index,
                             item.target_value);
            end
         end
         wrs_pkg::CMD_MERGE: begin
            cnt = (item.other_count > wrs_pkg::COUNT_CAP) ? wrs_pkg::COUNT_CAP
                                                          : item.other_count;
            osum = item.other_weight_sum;
            if (item.clamp_history && cnt > hist_limit) begin
               scaled = osum * hist_limit;
               osum = SUM_BITS'(scaled / cnt);
               cnt = hist_limit;
            end
            wb = (cnt != 0 && item.target_value != 0) ?
                 merge_weight(item.target_value, osum) : '0;
            count_add(cnt);
            if (wb != 0) begin
               res_sum = sum_saturating(res_sum, wb);
               draw_and_pick(wb, item.light_index, item.target_value);
            end
         end
         default: ;
      endcase
      r.pick_light = res_light;
      r.weight_sum = res_sum;
      r.sample_count = res_count;
      r.chosen_target = res_target;
      r.has_pick = res_has_pick;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, logic [63:0] expected_val,
                                       logic [63:0] actual_val);
      if (actual_val !== expected_val) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                  expected_val, actual_val);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reservoirs.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response beat, expected none, actual %p", $time, rsp_data);
         end else begin
            want = pending_reservoirs.pop_front();
            rsp_checked++;
            check_field("pick_light", 64'(want.pick_light), 64'(rsp_data.pick_light));
            check_field("weight_sum", 64'(want.weight_sum), 64'(rsp_data.weight_sum));
            check_field("sample_count", 64'(want.sample_count), 64'(rsp_data.sample_count));
            check_field("chosen_target", 64'(want.chosen_target),
                        64'(rsp_data.chosen_target));
            check_field("has_pick", 64'(want.has_pick), 64'(rsp_data.has_pick));
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // Ends the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses pending", $time,
                  pending_reservoirs.size());
         $display("tb_weighted_reservoir_sampler_unit: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic wrs_pkg::req_type random_fields();
      wrs_pkg::req_type item;
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      item.command = 2'($urandom_range(0, 3));
      item.seed = $urandom();
      item.light_index = $urandom();
      item.candidate_weight = $urandom();
      item.target_value = $urandom();
      item.other_weight_sum = wide[OSUM_W-1:0];
      item.other_count = COUNT_W'($urandom_range(0, 20'hFFFFF));
      item.clamp_history = 1'($urandom_range(0, 1));
      return item;
   endfunction

   function automatic wrs_pkg::req_type make_start(logic [31:0] seed);
      wrs_pkg::req_type item;
      item = random_fields();
      item.command = wrs_pkg::CMD_START;
      item.seed = seed;
      return item;
   endfunction

   function automatic wrs_pkg::req_type make_add(logic [31:0] light, logic [31:0] w,
                                                 logic [31:0] t);
      wrs_pkg::req_type item;
      item = random_fields();
      item.command = wrs_pkg::CMD_ADD;
      item.light_index = light;
      item.candidate_weight = w;
      item.target_value = t;
      return item;
   endfunction

   function automatic wrs_pkg::req_type make_merge(logic [31:0] light, logic [31:0] t,
                                                   logic [OSUM_W-1:0] osum,
                                                   logic [COUNT_W-1:0] cnt, logic clamp);
      wrs_pkg::req_type item;
      item = random_fields();
      item.command = wrs_pkg::CMD_MERGE;
      item.light_index = light;
      item.target_value = t;
      item.other_weight_sum = osum;
      item.other_count = cnt;
      item.clamp_history = clamp;
      return item;
   endfunction

   function automatic logic [31:0] light_value();
      case ($urandom_range(0, 9))
         0: return wrs_pkg::NO_LIGHT;
         1: return 32'd0;
         default: return $urandom();
      endcase
   endfunction

   // Used for candidate weights and merge targets alike.
   function automatic logic [31:0] q16_value();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 255);
         3: return $urandom_range(1, 32'h0001_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OSUM_W-1:0] osum_value();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return OSUM_W'($urandom_range(1, 1 << 20));
         default: return wide[OSUM_W-1:0];
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] count_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return wrs_pkg::COUNT_CAP;
         2: return COUNT_W'($urandom_range(0, 20'hFFFFF));
         default: return COUNT_W'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic send_beat(wrs_pkg::req_type item);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pending_reservoirs.insert(pending_reservoirs.size(), apply_to_reservoir(item));
      beats_sent++;
      if (item.command == wrs_pkg::CMD_MERGE && item.clamp_history)
         clamped_merges++;
   endtask

   // Holds the sender off until every response is back and the block has gone quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reservoirs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_history_limit(logic [COUNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hist_limit = value;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_corner_cases();
      wrs_pkg::req_type item;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_beat(make_add(32'h0000_0005, 32'd1, 32'h0001_0000));   // add before any start
      send_beat(make_start(32'd0));
      send_beat(make_add(32'h1234_5678, 32'd0, 32'h0001_0000));   // zero weight
      send_beat(make_add(wrs_pkg::NO_LIGHT, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // all-ones light
      send_beat(make_add(32'd0, 32'd1, 32'd0));
      item = random_fields();
      item.command = CMD_UNUSED;
      send_beat(item);
      send_beat(make_merge(32'd7, 32'hFFFF_FFFF, '1, '0, 1'b0));      // zero count
      send_beat(make_merge(32'd8, 32'd0, '1, 20'd10, 1'b0));          // zero target
      send_beat(make_merge(32'd9, 32'd1, 48'd1, 20'd5, 1'b0));        // weight rounds to zero
      send_beat(make_merge(32'd10, 32'hFFFF_FFFF, '1, 20'd1, 1'b0));  // sum saturates
      send_beat(make_add(32'd11, 32'hFFFF_FFFF, 32'd3));
      send_beat(make_merge(32'd12, 32'd2, 48'd99, 20'hFFFFF, 1'b0));  // count over the cap
      send_beat(make_start(32'hFFFF_FFFF));
      send_beat(make_merge(32'd13, 32'h0002_0000, osum_value(), 20'd100, 1'b1));
      send_beat(make_merge(32'd14, 32'h0001_8000, osum_value(), 20'd20, 1'b1));
      send_beat(make_merge(32'd15, 32'hFFFF_FFFF, '1, wrs_pkg::COUNT_CAP, 1'b1));
      send_beat(make_merge(32'd16, 32'h0001_0000, '0, 20'd3, 1'b0));  // empty incoming sum
      send_beat(make_add(32'd0, 32'd1, 32'hFFFF_FFFF));
      send_beat(make_merge(32'd17, 32'hFFFF_FFFF, 48'd1, 20'd21, 1'b1)); // clamp to zero sum
   endtask

   // Sweeps the history limit through its extremes, a clamp-all-away zero included.
   task automatic test_history_limit_register();
      logic [COUNT_W-1:0] limits[6] = '{20'd0, 20'd1, wrs_pkg::COUNT_CAP, 20'hFFFFF, 20'd37,
                                        wrs_pkg::MHC_RESET};
      send_idle_pct = 19;
      rsp_stall_pct = 19;
      foreach (limits[i]) begin
         wait_idle();
         write_history_limit(limits[i]);
         send_beat(make_start($urandom()));
         send_beat(make_merge(light_value(), 32'hFFFF_FFFF, '1, 20'hFFFFF, 1'b1));
         send_beat(make_merge(light_value(), $urandom(), osum_value(), count_value(), 1'b1));
         send_beat(make_merge(light_value(), $urandom(), osum_value(), count_value(), 1'b0));
      end
   endtask

   // Mostly well-formed runs: a start followed by adds and merges, with some raw noise.
   task automatic test_random_traffic(int sender_pct, int stall_pct, int beats);
      int sent;
      int pick;
      wait_idle();
      case ($urandom_range(0, 3))
         0: write_history_limit(COUNT_W'($urandom_range(1, 64)));
         1: write_history_limit(wrs_pkg::MHC_RESET);
         2: write_history_limit(wrs_pkg::COUNT_CAP);
         default: write_history_limit(COUNT_W'($urandom_range(0, 20'hFFFFF)));
      endcase
      send_idle_pct = sender_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < beats) begin
         send_beat(make_start($urandom()));
         sent++;
         repeat ($urandom_range(4, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
               send_beat(make_add(light_value(), q16_value(), $urandom()));
            else if (pick < 93)
               send_beat(make_merge(light_value(), q16_value(), osum_value(), count_value(),
                                    $urandom_range(0, 99) < 20));
            else
               send_beat(random_fields());
            sent++;
         end
         if ($urandom_range(0, 9) == 0)
            wait_idle();
      end
   endtask

   initial begin
      clear_reservoir();
      res_rng = '0;
      hist_limit = wrs_pkg::MHC_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_history_limit_register();
      test_random_traffic(0, 0, 300);
      test_random_traffic(63, 0, 300);
      test_random_traffic(0, 63, 300);
      test_random_traffic(19, 19, 300);
      wait_idle();
      $display("Sent %0d beats (%0d clamped merges) and checked %0d responses,", beats_sent,
               clamped_merges, rsp_checked);
      $display("with history limits from 0 to 1048575 and idle or stalls on both sides.");
      if (mismatch_count == 0)
         $display("tb_weighted_reservoir_sampler_unit: done, clean");
      else
         $display("tb_weighted_reservoir_sampler_unit: done, errors");
      $finish;
   end

endmodule
